// File: sv/assert_macros.svh
// Assertion helpers for the pixel store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: sv/dbps_pkg.sv
package dbps_pkg;

  localparam int DEPTH_W    = 15;
  localparam int ADDR_MAX_W = 20;
  localparam int RES_W      = DEPTH_W + 1;

  localparam logic [DEPTH_W-1:0] FAR_RESET = 15'h7FFF;

  typedef enum logic [2:0] {
    OP_DEPTH      = 3'd0,
    OP_OVERLAY    = 3'd1,
    OP_BACKGROUND = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic                  on;
    logic [ADDR_MAX_W-1:0] addr;
    logic                  value;
    logic [DEPTH_W-1:0]    depth;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
    logic exec;
  } back_status_t;

endpackage

// File: sv/dbps_ram.sv
module dbps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4032,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/dbps_fifo.sv
module dbps_fifo #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/dbps_front.sv
module dbps_front #(
  parameter int SCREEN_WIDTH  = 84,
  parameter int SCREEN_HEIGHT = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               hold,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         op,
  input  logic signed [15:0] x_coord,
  input  logic signed [15:0] y_coord,
  input  logic signed [15:0] depth,
  input  logic signed [1:0]  pixel_value,
  output logic               cmd_valid,
  output dbps_pkg::cmd_t     cmd,
  input  logic               cmd_pop
);

  localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int YW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int AMW = dbps_pkg::ADDR_MAX_W;

  logic           on_x;
  logic           on_y;
  logic           drawable;
  logic           keep;
  logic           q_full;
  logic           q_empty;
  dbps_pkg::cmd_t new_cmd;
  logic [$bits(dbps_pkg::cmd_t)-1:0] q_rdata;

  assign on_x     = !x_coord[15] && (x_coord[14:0] < 15'(SCREEN_WIDTH));
  assign on_y     = !y_coord[15] && (y_coord[14:0] < 15'(SCREEN_HEIGHT));
  assign drawable = !pixel_value[1];

  always_comb begin
    new_cmd.op    = dbps_pkg::op_t'(op);
    new_cmd.on    = on_x && on_y;
    new_cmd.addr  = AMW'(AMW'(y_coord[YW-1:0]) * AMW'(SCREEN_WIDTH))
                  + AMW'(x_coord[XW-1:0]);
    new_cmd.value = pixel_value[0];
    new_cmd.depth = depth[14:0];
    unique case (dbps_pkg::op_t'(op))
      dbps_pkg::OP_DEPTH:      keep = new_cmd.on && drawable && !depth[15];
      dbps_pkg::OP_OVERLAY:    keep = new_cmd.on && drawable;
      dbps_pkg::OP_BACKGROUND: keep = new_cmd.on && drawable;
      dbps_pkg::OP_CLEAR:      keep = 1'b1;
      dbps_pkg::OP_READ:       keep = 1'b1;
      default:                 keep = 1'b0;
    endcase
  end

  assign full      = q_full || hold;
  assign cmd_valid = !q_empty;
  assign cmd       = dbps_pkg::cmd_t'(q_rdata);

  dbps_fifo #(
    .WIDTH($bits(dbps_pkg::cmd_t))
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push && !full && keep),
    .wdata(new_cmd),
    .full (q_full),
    .pop  (cmd_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

endmodule

// File: sv/dbps_back.sv
module dbps_back #(
  parameter int SCREEN_WIDTH  = 84,
  parameter int SCREEN_HEIGHT = 48
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [dbps_pkg::DEPTH_W-1:0]     far_depth,
  input  logic                             cmd_valid,
  input  dbps_pkg::cmd_t                   cmd,
  output logic                             cmd_pop,
  output dbps_pkg::back_status_t           status,
  output logic                             empty,
  input  logic                             pop,
  output logic                             read_value,
  output logic [dbps_pkg::DEPTH_W-1:0]     read_depth
);

  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int DW     = dbps_pkg::DEPTH_W;
  localparam int RW     = dbps_pkg::RES_W;

  typedef enum logic [1:0] {S_SWEEP, S_IDLE, S_EXEC} state_t;

  state_t         state;
  state_t         state_next;
  dbps_pkg::cmd_t cur;
  logic [ADDR_W-1:0] sweep_addr;
  logic [DW-1:0]  sweep_depth;
  logic           init_busy;

  logic           ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [RW-1:0]  ram_wdata;
  logic [RW-1:0]  ram_rdata;
  logic [DW-1:0]  rd_depth;
  logic           res_push;
  logic [RW-1:0]  res_wdata;
  logic           res_full;
  logic [RW-1:0]  res_rdata;
  logic           take;

  assign rd_depth = ram_rdata[DW-1:0];
  assign take     = cmd_valid && ((cmd.op != dbps_pkg::OP_READ) || !res_full);

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = cur.addr[ADDR_W-1:0];
    ram_wdata  = {cur.value, cur.depth};
    res_push   = 1'b0;
    res_wdata  = '0;
    unique case (state)
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = {1'b0, sweep_depth};
        if (sweep_addr == ADDR_W'(PIXELS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          cmd_pop    = 1'b1;
          state_next = (cmd.op == dbps_pkg::OP_CLEAR) ? S_SWEEP : S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        unique case (cur.op)
          dbps_pkg::OP_DEPTH: begin
            ram_we = (cur.depth < rd_depth) || ((cur.depth == rd_depth) && cur.value);
          end
          dbps_pkg::OP_OVERLAY: begin
            ram_we    = 1'b1;
            ram_wdata = {cur.value, {DW{1'b0}}};
          end
          dbps_pkg::OP_BACKGROUND: begin
            ram_we    = (rd_depth >= far_depth);
            ram_wdata = {cur.value, far_depth};
          end
          dbps_pkg::OP_READ: begin
            res_push  = 1'b1;
            res_wdata = cur.on ? ram_rdata : '0;
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_addr  <= '0;
      sweep_depth <= dbps_pkg::FAR_RESET;
      init_busy   <= 1'b1;
    end else begin
      state <= state_next;
      if (state == S_SWEEP) begin
        sweep_addr <= sweep_addr + ADDR_W'(1);
        if (state_next == S_IDLE) begin
          init_busy <= 1'b0;
        end
      end
      if (state == S_IDLE && take) begin
        cur         <= cmd;
        sweep_addr  <= '0;
        sweep_depth <= far_depth;
      end
    end
  end

  assign status.init_busy = init_busy;
  assign status.exec      = (state == S_EXEC);

  dbps_ram #(
    .WIDTH(RW),
    .DEPTH(PIXELS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cmd.addr[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  dbps_fifo #(
    .WIDTH(RW)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_wdata),
    .full (res_full),
    .pop  (pop),
    .rdata(res_rdata),
    .empty(empty)
  );

  assign read_value = res_rdata[DW];
  assign read_depth = res_rdata[DW-1:0];

endmodule

// File: sv/depth_buffered_pixel_store.sv
// channel   handshake            payload
// request   push / full          op, x_coord, y_coord, depth, pixel_value
// result    empty / pop          read_value, read_depth
// config    cfg_valid/cfg_ready  cfg_data (far_depth)
//
// In the back end a point or read first reads the store, then does the write
// or the result push. Clear sweeps all W*H pixels, one pixel a cycle.
// After rst all W*H pixels (4032 at 84x48) of the store are swept; full is high.
// Up to two requests queue ahead of the back end; two results queue for pop.
// Off-screen or non-drawable points, negative-depth depth tests and undefined ops are dropped at the front.
`include "assert_macros.svh"

module depth_buffered_pixel_store #(
  parameter int SCREEN_WIDTH  = 84,
  parameter int SCREEN_HEIGHT = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [2:0]                   op,
  input  logic signed [15:0]           x_coord,
  input  logic signed [15:0]           y_coord,
  input  logic signed [15:0]           depth,
  input  logic signed [1:0]            pixel_value,
  output logic                         empty,
  input  logic                         pop,
  output logic                         read_value,
  output logic [dbps_pkg::DEPTH_W-1:0] read_depth,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dbps_pkg::DEPTH_W-1:0] cfg_data
);

  logic [dbps_pkg::DEPTH_W-1:0] far_depth;
  logic                         cmd_valid;
  dbps_pkg::cmd_t               cmd;
  logic                         cmd_pop;
  dbps_pkg::back_status_t       bstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      far_depth <= dbps_pkg::FAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      far_depth <= cfg_data;
    end
  end

  dbps_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (bstat.init_busy),
    .push       (push),
    .full       (full),
    .op         (op),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .depth      (depth),
    .pixel_value(pixel_value),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  dbps_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .far_depth (far_depth),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .status    (bstat),
    .empty     (empty),
    .pop       (pop),
    .read_value(read_value),
    .read_depth(read_depth)
  );

  `ASSERT_CLK(a_full_during_init, clk, rst, bstat.init_busy |-> full)
  `ASSERT_CLK(a_no_result_during_init, clk, rst, bstat.init_busy |-> empty)
  `ASSERT_CLK(a_result_from_exec, clk, rst, $fell(empty) |-> $past(bstat.exec))
  `ASSERT_CLK(a_pop_only_when_valid, clk, rst, cmd_pop |-> cmd_valid && !bstat.init_busy)

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int SCREEN_W = 84;
  localparam int SCREEN_H = 48;
  localparam int PIXELS = SCREEN_W * SCREEN_H;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 190;
  // one clear sweeping and two more queued behind it
  localparam int CLEAR_SETTLE = 3 * (PIXELS + 1) + 100;
  localparam int IDLE_LIMIT = 60000;
  localparam int RX_LONG_HOLD = 400;

  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam logic [1:0] PV_CLEAR = 2'b00;
  localparam logic [1:0] PV_SET = 2'b01;
  localparam logic [1:0] PV_BAD = 2'b10;
  localparam logic [1:0] PV_TRANSPARENT = 2'b11;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] dep;
    logic [1:0]  pv;
  } req_t;

  typedef struct packed {
    logic                         val;
    logic [dbps_pkg::DEPTH_W-1:0] dep;
  } pixel_rd_t;

  typedef struct packed {
    req_t      r;
    logic      typed;
    pixel_rd_t rd;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [2:0] op = 3'd0;
  logic signed [15:0] x_coord = 16'sd0;
  logic signed [15:0] y_coord = 16'sd0;
  logic signed [15:0] depth = 16'sd0;
  logic signed [1:0] pixel_value = 2'sd0;
  logic empty;
  logic pop = 1'b0;
  logic read_value;
  logic [dbps_pkg::DEPTH_W-1:0] read_depth;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dbps_pkg::DEPTH_W-1:0] cfg_data = '0;

  depth_buffered_pixel_store #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .op         (op),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .depth      (depth),
    .pixel_value(pixel_value),
    .empty      (empty),
    .pop        (pop),
    .read_value (read_value),
    .read_depth (read_depth),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // shadow frame store
  logic                         shadow_val [PIXELS];
  logic [dbps_pkg::DEPTH_W-1:0] shadow_dep [PIXELS];
  logic [dbps_pkg::DEPTH_W-1:0] far_reg;

  pixel_rd_t pending_reads[$];
  dir_row_t  dir_rows[$];

  int errors = 0;
  int req_count = 0;
  int clear_count = 0;
  int pixel_writes = 0;
  int reads_checked = 0;
  int far_settings = 1;
  bit rx_stall_req = 1'b0;

  task automatic wipe_shadow();
    for (int i = 0; i < PIXELS; i++) begin
      shadow_val[i] = 1'b0;
      shadow_dep[i] = far_reg;
    end
  endtask

  task automatic apply_req(input req_t r, output bit has_rd, output pixel_rd_t rd);
    int xi, yi, di, cur, slot;
    bit on, drawable;
    xi = $signed(r.x);
    yi = $signed(r.y);
    di = $signed(r.dep);
    on = (xi >= 0) && (xi < SCREEN_W) && (yi >= 0) && (yi < SCREEN_H);
    slot = on ? yi * SCREEN_W + xi : 0;
    drawable = (r.pv == PV_CLEAR) || (r.pv == PV_SET);
    has_rd = 1'b0;
    rd = '0;
    case (r.op)
      dbps_pkg::OP_DEPTH: begin
        if (di >= 0 && on && drawable) begin
          cur = shadow_dep[slot];
          if (di < cur || (di == cur && r.pv == PV_SET)) begin
            shadow_val[slot] = r.pv[0];
            shadow_dep[slot] = r.dep[dbps_pkg::DEPTH_W-1:0];
            pixel_writes++;
          end
        end
      end
      dbps_pkg::OP_OVERLAY: begin
        if (on && drawable) begin
          shadow_val[slot] = r.pv[0];
          shadow_dep[slot] = '0;
          pixel_writes++;
        end
      end
      dbps_pkg::OP_BACKGROUND: begin
        if (on && drawable && shadow_dep[slot] >= far_reg) begin
          shadow_val[slot] = r.pv[0];
          shadow_dep[slot] = far_reg;
          pixel_writes++;
        end
      end
      dbps_pkg::OP_CLEAR: begin
        wipe_shadow();
        clear_count++;
      end
      dbps_pkg::OP_READ: begin
        has_rd = 1'b1;
        if (on) begin
          rd.val = shadow_val[slot];
          rd.dep = shadow_dep[slot];
        end
      end
      default: ;
    endcase
  endtask

  function automatic req_t make_req(logic [2:0] o, int x, int y, int d, logic [1:0] pv);
    req_t r;
    r.op = o;
    r.x = x[15:0];
    r.y = y[15:0];
    r.dep = d[15:0];
    r.pv = pv;
    return r;
  endfunction

  task automatic add_row(input logic [2:0] o, input int x, input int y, input int d,
                         input logic [1:0] pv, input bit typed, input bit v, input int dep);
    dir_row_t row;
    row.r = make_req(o, x, y, d, pv);
    row.typed = typed;
    row.rd.val = v;
    row.rd.dep = dep[dbps_pkg::DEPTH_W-1:0];
    dir_rows.push_back(row);
  endtask

  function automatic int edge_coord(int lim);
    case ($urandom_range(3))
      0: return -1;
      1: return 0;
      2: return lim - 1;
      default: return lim;
    endcase
  endfunction

  function automatic req_t random_req();
    req_t r;
    int k, x, y, d;
    k = $urandom_range(999);
    if (k < 400) r.op = dbps_pkg::OP_DEPTH;
    else if (k < 500) r.op = dbps_pkg::OP_OVERLAY;
    else if (k < 620) r.op = dbps_pkg::OP_BACKGROUND;
    else if (k < 960) r.op = dbps_pkg::OP_READ;
    else if (k < 970) r.op = dbps_pkg::OP_CLEAR;
    else r.op = 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
    // mostly a small window so that points and reads meet on the same pixels
    k = $urandom_range(99);
    if (k < 75) begin
      x = $urandom_range(5);
      y = $urandom_range(3);
    end else if (k < 85) begin
      x = $urandom_range(SCREEN_W - 1);
      y = $urandom_range(SCREEN_H - 1);
    end else if (k < 92) begin
      x = edge_coord(SCREEN_W);
      y = edge_coord(SCREEN_H);
    end else begin
      x = $urandom;
      y = $urandom;
    end
    k = $urandom_range(99);
    if (k < 35) d = $urandom_range(7);
    else if (k < 55) begin
      d = int'(far_reg) + int'($urandom_range(4)) - 2;
      if (d < 0) d = 0;
      if (d > 32767) d = 32767;
    end else if (k < 70) d = $urandom;
    else if (k < 80) d = -int'($urandom_range(3, 1));
    else if (k < 90) d = 32767 - int'($urandom_range(1));
    else d = $urandom_range(32767);
    r.x = x[15:0];
    r.y = y[15:0];
    r.dep = d[15:0];
    k = $urandom_range(99);
    if (k < 40) r.pv = PV_SET;
    else if (k < 80) r.pv = PV_CLEAR;
    else if (k < 90) r.pv = PV_TRANSPARENT;
    else r.pv = PV_BAD;
    return r;
  endfunction

  task automatic issue_req(input req_t r, input bit typed, input pixel_rd_t typed_rd);
    bit has_rd;
    pixel_rd_t rd;
    push <= 1'b1;
    op <= r.op;
    x_coord <= r.x;
    y_coord <= r.y;
    depth <= r.dep;
    pixel_value <= r.pv;
    do @(posedge clk); while (full);
    apply_req(r, has_rd, rd);
    if (has_rd) pending_reads.push_back(typed ? typed_rd : rd);
    req_count++;
  endtask

  task automatic req_gap(input int gap, input bit last, input bit drain_first);
    if (gap > 0 || last || drain_first) begin
      push <= 1'b0;
      if (drain_first) while (pending_reads.size() != 0) @(posedge clk);
      repeat ((gap == 0) ? 1 : gap) @(posedge clk);
    end
  endtask

  function automatic int pick_gap(int idx);
    int k;
    if (idx % 64 < 16) return 0;
    k = $urandom_range(99);
    if (k < 70) return 0;
    if (k < 95) return $urandom_range(3, 1);
    return $urandom_range(50, 10);
  endfunction

  task automatic set_far_depth(input logic [dbps_pkg::DEPTH_W-1:0] v);
    while (pending_reads.size() != 0) @(posedge clk);
    // a clear gives no result and may still be sweeping
    repeat (CLEAR_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    far_reg = v;
    far_settings++;
  endtask

  task automatic check_read();
    pixel_rd_t exp_rd;
    if (pending_reads.size() == 0) begin
      $display("%0t: unexpected read result value %0d depth %0d", $time, read_value,
               read_depth);
      errors++;
    end else begin
      exp_rd = pending_reads.pop_front();
      reads_checked++;
      if (read_value !== exp_rd.val) begin
        $display("%0t: read_value expected %0d got %0d", $time, exp_rd.val, read_value);
        errors++;
      end
      if (read_depth !== exp_rd.dep) begin
        $display("%0t: read_depth expected %0d got %0d", $time, exp_rd.dep, read_depth);
        errors++;
      end
    end
  endtask

  // result side
  initial begin
    int hold, cyc;
    bit long_done;
    hold = 0;
    cyc = 0;
    long_done = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (pop && !empty) check_read();
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else if (rx_stall_req && !long_done) begin
        pop <= 1'b0;
        hold = RX_LONG_HOLD;
        long_done = 1'b1;
      end else begin
        pop <= 1'b1;
        if ((cyc / 300) % 4 != 0) begin
          int k;
          k = $urandom_range(99);
          if (k < 55) hold = 0;
          else if (k < 92) hold = $urandom_range(3, 1);
          else hold = $urandom_range(40, 8);
        end
      end
    end
  end

  always @(posedge clk) begin
    int idle_cycles;
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [dbps_pkg::DEPTH_W-1:0] far_plan [RAND_PHASES];
    dir_row_t row;
    far_reg = dbps_pkg::FAR_RESET;
    wipe_shadow();
    far_plan[0] = dbps_pkg::FAR_RESET;
    far_plan[1] = '0;
    far_plan[2] = dbps_pkg::FAR_RESET;
    far_plan[3] = 15'd300;
    far_plan[4] = 15'd1;
    far_plan[5] = 15'($urandom_range(32767));
    far_plan[6] = 15'd4;
    far_plan[7] = 15'($urandom_range(200));

    add_row(dbps_pkg::OP_READ, 0, 0, 0, PV_CLEAR, 1, 0, dbps_pkg::FAR_RESET);
    add_row(dbps_pkg::OP_READ, SCREEN_W - 1, SCREEN_H - 1, 0, PV_SET, 1, 0,
            dbps_pkg::FAR_RESET);
    add_row(dbps_pkg::OP_READ, -1, 0, 0, PV_SET, 1, 0, 0);
    add_row(dbps_pkg::OP_READ, SCREEN_W, 0, 0, PV_SET, 1, 0, 0);
    add_row(dbps_pkg::OP_READ, 0, SCREEN_H, 0, PV_SET, 1, 0, 0);
    add_row(dbps_pkg::OP_READ, -32768, 32767, 0, PV_SET, 1, 0, 0);
    add_row(dbps_pkg::OP_DEPTH, 0, 0, 0, PV_SET, 0, 0, 0);
    add_row(dbps_pkg::OP_READ, 0, 0, 0, PV_CLEAR, 1, 1, 0);
    add_row(dbps_pkg::OP_DEPTH, 0, 0, 0, PV_CLEAR, 0, 0, 0);    // tie with value 0 loses
    add_row(dbps_pkg::OP_READ, 0, 0, 0, PV_CLEAR, 1, 1, 0);
    add_row(dbps_pkg::OP_DEPTH, 1, 0, -1, PV_SET, 0, 0, 0);     // negative depth
    add_row(dbps_pkg::OP_DEPTH, 1, 0, -32768, PV_SET, 0, 0, 0);
    add_row(dbps_pkg::OP_READ, 1, 0, 0, PV_CLEAR, 1, 0, dbps_pkg::FAR_RESET);
    add_row(dbps_pkg::OP_DEPTH, 1, 0, 32767, PV_SET, 0, 0, 0);  // tie with value 1 wins
    add_row(dbps_pkg::OP_READ, 1, 0, 0, PV_CLEAR, 1, 1, dbps_pkg::FAR_RESET);
    add_row(dbps_pkg::OP_OVERLAY, SCREEN_W - 1, SCREEN_H - 1, 500, PV_TRANSPARENT, 0, 0, 0);
    add_row(dbps_pkg::OP_OVERLAY, SCREEN_W - 1, SCREEN_H - 1, -5, PV_SET, 0, 0, 0);
    add_row(dbps_pkg::OP_READ, SCREEN_W - 1, SCREEN_H - 1, 0, PV_CLEAR, 1, 1, 0);
    add_row(dbps_pkg::OP_BACKGROUND, 2, 0, 0, PV_BAD, 0, 0, 0);
    add_row(dbps_pkg::OP_BACKGROUND, 2, 0, 0, PV_SET, 0, 0, 0);
    add_row(dbps_pkg::OP_READ, 2, 0, 0, PV_CLEAR, 0, 0, 0);
    add_row(OP_RSVD_LO, 2, 0, 0, PV_CLEAR, 0, 0, 0);
    add_row(OP_RSVD_HI, 2, 0, 0, PV_CLEAR, 0, 0, 0);
    add_row(dbps_pkg::OP_DEPTH, SCREEN_W, SCREEN_H - 1, 1, PV_SET, 0, 0, 0);
    add_row(dbps_pkg::OP_CLEAR, 0, 0, 0, PV_TRANSPARENT, 0, 0, 0);
    add_row(dbps_pkg::OP_READ, 0, 0, 0, PV_CLEAR, 1, 0, dbps_pkg::FAR_RESET);
    add_row(dbps_pkg::OP_READ, 2, 0, 0, PV_CLEAR, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    while (dir_rows.size() != 0) begin
      row = dir_rows.pop_front();
      issue_req(row.r, row.typed, row.rd);
      req_gap(0, dir_rows.size() == 0, 1'b0);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (far_plan[ph] != far_reg || ph > 0) set_far_depth(far_plan[ph]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == 10) rx_stall_req = 1'b1;
        issue_req(random_req(), 1'b0, '0);
        req_gap(pick_gap(i), i == PHASE_ITEMS - 1, ph == 4 && i == 60);
      end
    end

    while (pending_reads.size() != 0) @(posedge clk);
    repeat (CLEAR_SETTLE) @(posedge clk);
    errors += pending_reads.size();

    $display("covered %0d requests: %0d clears, %0d pixel updates, %0d reads checked",
             req_count, clear_count, pixel_writes, reads_checked);
    $display("over %0d far_depth settings with random gaps and back-pressure on both sides",
             far_settings);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
